// ===== sv/cxwd_pkg.sv =====
// Shared constants and types for the chained XOR word decryptor.
package cxwd_pkg;

  localparam int unsigned LaneW   = 32;
  localparam int unsigned NumLane = 2;
  localparam int unsigned WordW   = LaneW * NumLane;
  localparam int unsigned CountW  = 29;

  localparam logic [LaneW-1:0]  KEY_INIT   = 32'hA73C5F9D;
  localparam logic [LaneW-1:0]  KEY_STEP   = 32'hCE24F523;
  localparam logic [LaneW-1:0]  CHAIN_MASK = 32'hFEC9753E;
  localparam logic [CountW-1:0] COUNT_MAX  = {CountW{1'b1}};

  // cipher_mode codes
  localparam logic [1:0] MODE_BYPASS = 2'd0;
  localparam logic [1:0] MODE_V1     = 2'd1;
  localparam logic [1:0] MODE_V3     = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_SEED   = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  // per-beat control shared by all lanes
  typedef struct packed {
    logic             accept;  // beat taken this cycle
    logic             first;   // reload key and chain before use
    logic             active;  // decrypt this beat, else pass through
    logic [LaneW-1:0] start;   // chain start for a reload
  } lane_ctrl_t;

endpackage

// ===== sv/cxwd_lane.sv =====
// One 32-bit decrypt lane: running key, chain value and the XOR datapath.
module cxwd_lane
  import cxwd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lane_ctrl_t       ctrl_i,
  input  logic [LaneW-1:0] cipher_i,
  output logic [LaneW-1:0] plain_o
);

  logic [LaneW-1:0] key_q, key_d;
  logic [LaneW-1:0] chain_q, chain_d;
  logic [LaneW-1:0] key_base, chain_base, key_new, plain_new;

  always_comb begin
    key_base   = ctrl_i.first ? KEY_INIT : key_q;
    chain_base = ctrl_i.first ? ctrl_i.start : chain_q;
    key_new    = (key_base + KEY_STEP) ^ chain_base;
    plain_new  = cipher_i ^ key_new;
    plain_o    = ctrl_i.active ? plain_new : cipher_i;
    key_d      = key_q;
    chain_d    = chain_q;
    if (ctrl_i.accept) begin
      if (ctrl_i.active) begin
        key_d   = key_new;
        chain_d = plain_new;
      end else begin
        key_d   = key_base;
        chain_d = chain_base;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= KEY_INIT;
      chain_q <= '0;
    end else begin
      key_q   <= key_d;
      chain_q <= chain_d;
    end
  end

endmodule

// ===== sv/chained_xor_word_decrypt_top.sv =====
// Top level of the chained XOR word decryptor: config, word count, lanes, output register.
// An accepted input beat's result is registered in the output register.
// Throughput: one word per cycle while the input is not stalled; both lanes update key and chain in the accept cycle.
// The input is stalled only while a held result is itself stalled downstream.
// Reset: keys to 0xA73C5F9D, chains, word count and config registers to zero, output empty.
module chained_xor_word_decrypt_top
  import cxwd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [LaneW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [WordW-1:0] cipher_word_i,
  input  logic             first_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [WordW-1:0] plain_word_o
);

  logic [1:0]        mode_q;
  logic [LaneW-1:0]  seed_q, length_q;
  logic [CountW-1:0] words_q, words_d, words_base;
  logic              out_valid_q;
  logic [WordW-1:0]  plain_q;
  logic [WordW-1:0]  plain_lanes;
  logic              acc;
  logic              mode_on;
  lane_ctrl_t        ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BYPASS;
      seed_q   <= '0;
      length_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_SEED:   seed_q   <= cfg_data_i;
        REG_LENGTH: length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;

  always_comb begin
    mode_on     = mode_q inside {MODE_V1, MODE_V3};
    words_base  = first_word_i ? '0 : words_q;
    words_d     = (words_base == COUNT_MAX) ? words_base : words_base + 1'b1;
    ctrl.accept = acc;
    ctrl.first  = first_word_i;
    ctrl.active = mode_on && (words_base < length_q[LaneW-1:3]);
    case (mode_q)
      MODE_V1: ctrl.start = length_q ^ CHAIN_MASK;
      MODE_V3: ctrl.start = (seed_q + length_q) ^ CHAIN_MASK;
      default: ctrl.start = '0;
    endcase
  end

  for (genvar l = 0; l < NumLane; l++) begin : g_lane
    cxwd_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .cipher_i (cipher_word_i[l*LaneW +: LaneW]),
      .plain_o  (plain_lanes[l*LaneW +: LaneW])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        words_q     <= words_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // merge lanes into the result beat
  always_ff @(posedge clk_i) begin
    if (acc) begin
      plain_q <= plain_lanes;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_word_o = plain_q;

  a_acc_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_q)
    else $error("accepted beat did not reach the output register");

  a_bypass_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && mode_q == MODE_BYPASS |=> plain_q == $past(cipher_word_i))
    else $error("bypass beat was altered");

  a_first_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && first_word_i |=> words_q == CountW'(1))
    else $error("word count not restarted on first word");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !first_word_i |=> words_q >= $past(words_q))
    else $error("word count went backward");

endmodule

// ===== tb/chained_xor_word_decrypt_top_tb.sv =====
// Self-checking testbench for the chained XOR word decryptor: directed table, random files.
module chained_xor_word_decrypt_top_tb
  import cxwd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 60;
  localparam int         PHASE_ITEMS = 450;
  localparam logic [WordW-1:0] ONES  = {WordW{1'b1}};

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [1:0]       idx;
    logic [LaneW-1:0] data;
    logic [WordW-1:0] word;
    logic             first;
    logic             typed;  // want is given literally
    logic [WordW-1:0] want;
  } dir_row_t;

  localparam int NDIR = 29;

  dir_row_t dir_rows [NDIR] = '{
    // no first word since reset: chains are zero
    '{ROW_REG,  REG_MODE,   LaneW'(MODE_V1), '0, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_LENGTH, 32'd64,       '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h0, 1'b0, 1'b1, 64'h756154C0_756154C0},
    '{ROW_WORD, REG_MODE,   '0, ONES,  1'b0, 1'b0, '0},
    // bypass
    '{ROW_REG,  REG_MODE,   LaneW'(MODE_BYPASS), '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h01234567_89ABCDEF, 1'b1, 1'b1, 64'h01234567_89ABCDEF},
    '{ROW_WORD, REG_MODE,   '0, ONES,  1'b0, 1'b1, ONES},
    // one full word, then past the end
    '{ROW_REG,  REG_MODE,   LaneW'(MODE_V1), '0, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_LENGTH, 32'd8,        '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h0, 1'b1, 1'b1, 64'h8BA821F6_8BA821F6},
    '{ROW_WORD, REG_MODE,   '0, ONES,  1'b0, 1'b1, ONES},
    // zero length
    '{ROW_REG,  REG_LENGTH, 32'd0,        '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'hDEADBEEF_CAFEF00D, 1'b1, 1'b1, 64'hDEADBEEF_CAFEF00D},
    // max length and seed
    '{ROW_REG,  REG_LENGTH, 32'hFFFFFFFF, '0, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_SEED,   32'hFFFFFFFF, '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h13579BDF_2468ACE0, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, ONES,  1'b0, 1'b0, '0},
    // seeded chain start, reload mid-file
    '{ROW_REG,  REG_MODE,   LaneW'(MODE_V3), '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'hA5A5A5A5_5A5A5A5A, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h80000000_00000001, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h7FFFFFFF_FFFFFFFE, 1'b1, 1'b0, '0},
    // trailing partial word
    '{ROW_REG,  REG_SEED,   32'd0,        '0, 1'b0, 1'b0, '0},
    '{ROW_REG,  REG_LENGTH, 32'd20,       '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h11223344_55667788, 1'b1, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h99AABBCC_DDEEFF00, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'hFEDCBA98_76543210, 1'b0, 1'b0, '0},
    // mode with no meaning passes through
    '{ROW_REG,  REG_MODE,   LaneW'(MODE_UNUSED), '0, 1'b0, 1'b0, '0},
    '{ROW_WORD, REG_MODE,   '0, 64'h55555555_AAAAAAAA, 1'b1, 1'b1, 64'h55555555_AAAAAAAA}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [LaneW-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [WordW-1:0] cipher_word_i;
  logic             first_word_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [WordW-1:0] plain_word_o;

  // beat side info, driven alongside the payload
  logic             beat_typed;
  logic [WordW-1:0] beat_want;

  // predictor state
  logic [1:0]        mode_r;
  logic [LaneW-1:0]  seed_r;
  logic [LaneW-1:0]  len_r;
  logic [LaneW-1:0]  key_r   [NumLane];
  logic [LaneW-1:0]  chain_r [NumLane];
  logic [CountW-1:0] words_seen;

  logic [WordW-1:0] pending_plain [$];
  logic [WordW-1:0] sb_want;
  int               fail_cnt = 0;
  int               cycle_cnt = 0;
  int               tx_idle_pct = 0;
  int               rx_idle_pct = 0;
  int               phase = 0;
  int               hold_left = 0;
  bit               hold_done = 1'b0;

  chained_xor_word_decrypt_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cipher_word_i(cipher_word_i),
    .first_word_i (first_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .plain_word_o (plain_word_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [WordW-1:0] decrypt_word(input logic [WordW-1:0] cw,
                                                    input logic fw);
    logic [LaneW-1:0] start;
    logic [LaneW-1:0] k;
    logic [LaneW-1:0] p;
    logic [WordW-1:0] res;
    res = cw;
    if (fw) begin
      case (mode_r)
        MODE_V1: start = len_r ^ CHAIN_MASK;
        MODE_V3: start = (seed_r + len_r) ^ CHAIN_MASK;
        default: start = '0;
      endcase
      for (int l = 0; l < NumLane; l++) begin
        key_r[l]   = KEY_INIT;
        chain_r[l] = start;
      end
      words_seen = '0;
    end
    if ((mode_r == MODE_V1 || mode_r == MODE_V3) && words_seen < (len_r >> 3)) begin
      for (int l = 0; l < NumLane; l++) begin
        k = (key_r[l] + KEY_STEP) ^ chain_r[l];
        p = cw[l*LaneW +: LaneW] ^ k;
        key_r[l]   = k;
        chain_r[l] = p;
        res[l*LaneW +: LaneW] = p;
      end
    end
    if (words_seen != COUNT_MAX) words_seen = words_seen + 1'b1;
    return res;
  endfunction

  // scoreboard: register writes and input beats feed the predictor, output beats are checked
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mode_r     = MODE_BYPASS;
      seed_r     = '0;
      len_r      = '0;
      key_r[0]   = KEY_INIT;
      key_r[1]   = KEY_INIT;
      chain_r[0] = '0;
      chain_r[1] = '0;
      words_seen = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:   mode_r = cfg_data_i[1:0];
          REG_SEED:   seed_r = cfg_data_i;
          REG_LENGTH: len_r  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (pending_plain.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected plain_word %h", plain_word_o);
        end else begin
          sb_want = pending_plain.pop_front();
          if (plain_word_o !== sb_want) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("plain_word mismatch: expected %h got %h", sb_want, plain_word_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        sb_want = decrypt_word(cipher_word_i, first_word_i);
        if (beat_typed) sb_want = beat_want;
        pending_plain = {pending_plain, sb_want};
      end
    end
  end

  // receiver: random stalls, one long hold-off when the last phase starts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (phase == 3 && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(input logic [WordW-1:0] w, input logic f,
                           input logic typed, input logic [WordW-1:0] want);
    in_valid_i    <= 1'b1;
    cipher_word_i <= w;
    first_word_i  <= f;
    beat_typed    <= typed;
    beat_want     <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // registers change only with the pipe drained
  task automatic write_reg(input logic [1:0] idx, input logic [LaneW-1:0] val);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_plain.size() != 0);
    repeat (2) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_files(input int n_items);
    int               sent;
    int               nwords;
    int               pick;
    logic [1:0]       m;
    logic [LaneW-1:0] v;
    bit               no_first;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 4)       m = MODE_V1;
        else if (pick < 8)  m = MODE_V3;
        else if (pick == 8) m = MODE_BYPASS;
        else                m = MODE_UNUSED;
        write_reg(REG_MODE, {30'd0, m});
        pick = $urandom_range(0, 9);
        if (pick == 0)      v = '0;
        else if (pick == 1) v = '1;
        else if (pick == 2) v = $urandom;
        else                v = $urandom_range(0, 160);
        write_reg(REG_LENGTH, v);
        pick = $urandom_range(0, 5);
        v = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
        write_reg(REG_SEED, v);
      end
      nwords   = $urandom_range(1, 24);
      no_first = ($urandom_range(0, 11) == 0);
      for (int i = 0; i < nwords; i++) begin
        // mostly well-formed files; a stray reload now and then
        send_beat({$urandom, $urandom},
                  (i == 0 && !no_first) || ($urandom_range(0, 29) == 0), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_MODE;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    cipher_word_i = '0;
    first_word_i  = 1'b0;
    beat_typed    = 1'b0;
    beat_want     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_REG)
        write_reg(dir_rows[r].idx, dir_rows[r].data);
      else
        send_beat(dir_rows[r].word, dir_rows[r].first, dir_rows[r].typed, dir_rows[r].want);
    end

    phase = 1; tx_idle_pct = 6;  rx_idle_pct = 74;
    run_files(PHASE_ITEMS);
    phase = 2; tx_idle_pct = 74; rx_idle_pct = 6;
    run_files(PHASE_ITEMS);
    phase = 3; tx_idle_pct = 0;  rx_idle_pct = 0;
    run_files(PHASE_ITEMS);

    in_valid_i <= 1'b0;
    while (pending_plain.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/cxwd_pkg.sv
sv/cxwd_lane.sv
sv/chained_xor_word_decrypt_top.sv
tb/chained_xor_word_decrypt_top_tb.sv
